// ===== rtl/vsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vsc_pkg: shared types and constants of the viewport scroll camera
// Holds the command codes, register map, field widths and the structs that
// travel between the camera datapath, the register file and the top level.
// ----------------------------------------------------------------------------
package vsc_pkg;

  // Fixed-point format of a camera position: 15 integer bits, 16 fraction bits.
  localparam int unsigned FracBits = 16;
  localparam int unsigned PosW     = 15;
  localparam int unsigned FixW     = PosW + FracBits;
  localparam int unsigned DimW     = 16;
  localparam logic [FixW:0] HalfOne = (FixW + 1)'(1) << (FracBits - 1);

  // Configuration port geometry.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register reset values.
  localparam logic [DimW-1:0] WorldWidthRst  = 16'd320;
  localparam logic [DimW-1:0] WorldHeightRst = 16'd256;
  localparam logic [DimW-1:0] ViewWidthRst   = 16'd320;
  localparam logic [DimW-1:0] ViewHeightRst  = 16'd256;

  // Command codes carried in the mode field. Code seven is unused.
  typedef enum logic [2:0] {
    ModeRestart  = 3'd0,
    ModeSetInt   = 3'd1,
    ModeMoveInt  = 3'd2,
    ModeCenter   = 3'd3,
    ModeTick     = 3'd4,
    ModeSetFix   = 3'd5,
    ModeMoveFix  = 3'd6
  } vsc_mode_e;

  // Register indexes (word address on the configuration port).
  typedef enum logic [2:0] {
    RegWorldWidth  = 3'd0,
    RegWorldHeight = 3'd1,
    RegViewWidth   = 3'd2,
    RegViewHeight  = 3'd3,
    RegDoubleBuf   = 3'd4
  } vsc_reg_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [DimW-1:0] world_width;
    logic [DimW-1:0] world_height;
    logic [DimW-1:0] view_width;
    logic [DimW-1:0] view_height;
    logic            double_buffer;
  } vsc_cfg_t;

  // Per-transaction control shared by both axes.
  typedef struct packed {
    logic      advance;
    vsc_mode_e mode;
    logic      sel_q;
    logic      sel_d;
  } vsc_ctrl_t;

  // Per-axis result of one transaction.
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [DimW-1:0] scroll;
    logic [DimW-1:0] delta;
    logic            moved;
  } vsc_axis_res_t;

endpackage

// ===== rtl/vsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vsc_cfg_regs: configuration register file
// APB-style slave holding the world size, view size and double-buffer enable.
// Writes complete in the access phase; reads return the stored values.
// ----------------------------------------------------------------------------
module vsc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vsc_pkg::AddrW-1:0]  paddr,
  input  logic [vsc_pkg::DataW-1:0]  pwdata,
  output logic [vsc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output vsc_pkg::vsc_cfg_t          cfg_o
);
  import vsc_pkg::*;

  vsc_cfg_t cfg_q;
  vsc_reg_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = vsc_reg_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel & penable & pwrite;

  // Register writes; addresses beyond the map are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.world_width   <= WorldWidthRst;
      cfg_q.world_height  <= WorldHeightRst;
      cfg_q.view_width    <= ViewWidthRst;
      cfg_q.view_height   <= ViewHeightRst;
      cfg_q.double_buffer <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        RegWorldWidth:  cfg_q.world_width   <= pwdata[DimW-1:0];
        RegWorldHeight: cfg_q.world_height  <= pwdata[DimW-1:0];
        RegViewWidth:   cfg_q.view_width    <= pwdata[DimW-1:0];
        RegViewHeight:  cfg_q.view_height   <= pwdata[DimW-1:0];
        RegDoubleBuf:   cfg_q.double_buffer <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegWorldWidth:  prdata = DataW'(cfg_q.world_width);
      RegWorldHeight: prdata = DataW'(cfg_q.world_height);
      RegViewWidth:   prdata = DataW'(cfg_q.view_width);
      RegViewHeight:  prdata = DataW'(cfg_q.view_height);
      RegDoubleBuf:   prdata = DataW'(cfg_q.double_buffer);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/vsc_axis.sv =====
// ----------------------------------------------------------------------------
// vsc_axis: camera state and update logic for one axis
// Keeps the 15.16 position, the position at the last frame tick and the two
// history entries, applies one command per advance and forms the result.
// ----------------------------------------------------------------------------
module vsc_axis (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vsc_pkg::vsc_ctrl_t          ctrl_i,
  input  logic [vsc_pkg::PosW-1:0]    coord_i,
  input  logic signed [15:0]          step_i,
  input  logic signed [31:0]          fixed_i,
  input  logic [vsc_pkg::DimW-1:0]    world_i,
  input  logic [vsc_pkg::DimW-1:0]    view_i,
  output vsc_pkg::vsc_axis_res_t      res_o
);
  import vsc_pkg::*;

  logic [FixW-1:0] pos_q, pos_d;
  logic [FixW-1:0] last_q, last_d;
  logic [PosW-1:0] hist0_q, hist0_d;
  logic [PosW-1:0] hist1_q, hist1_d;

  logic [DimW:0]   max_diff;
  logic [PosW-1:0] max_pos;
  logic [FixW+1:0] add_a, add_b, sum;
  logic [FixW:0]   hi_lim;
  logic [FixW-1:0] clamped;
  logic [DimW-1:0] ctr_diff;
  logic [PosW-1:0] ctr_pos;
  logic [PosW-1:0] hist_sel;
  logic [FixW:0]   round_sum;

  // Upper limit: world minus view, floored at zero and capped at the position range.
  always_comb begin
    max_diff = {1'b0, world_i} - {1'b0, view_i};
    if (max_diff[DimW]) begin
      max_pos = '0;
    end else if (max_diff[DimW-1]) begin
      max_pos = '1;
    end else begin
      max_pos = max_diff[PosW-1:0];
    end
  end

  // Exact add for the move commands (a set passes the value through), then clamp.
  always_comb begin
    add_a = (ctrl_i.mode == ModeSetFix) ? '0 : {2'b00, pos_q};
    if (ctrl_i.mode == ModeMoveInt) begin
      add_b = {step_i[15], step_i, {FracBits{1'b0}}};
    end else begin
      add_b = {fixed_i[31], fixed_i};
    end
    sum    = add_a + add_b;
    hi_lim = {1'b0, max_pos, {FracBits{1'b0}}};
    if (sum[FixW+1]) begin
      clamped = '0;
    end else if (sum[FixW:0] > hi_lim) begin
      clamped = hi_lim[FixW-1:0];
    end else begin
      clamped = sum[FixW-1:0];
    end
  end

  // Centering: coordinate minus half the view, clamped to the limit.
  always_comb begin
    ctr_diff = {1'b0, coord_i} - {1'b0, view_i[DimW-1:1]};
    if (ctr_diff[DimW-1]) begin
      ctr_pos = '0;
    end else if (ctr_diff[PosW-1:0] > max_pos) begin
      ctr_pos = max_pos;
    end else begin
      ctr_pos = ctr_diff[PosW-1:0];
    end
  end

  // Next state for the command in flight.
  always_comb begin
    pos_d   = pos_q;
    last_d  = last_q;
    hist0_d = hist0_q;
    hist1_d = hist1_q;
    if (ctrl_i.advance) begin
      case (ctrl_i.mode)
        ModeRestart: begin
          pos_d   = {coord_i, {FracBits{1'b0}}};
          last_d  = {coord_i, {FracBits{1'b0}}};
          hist0_d = coord_i;
          hist1_d = coord_i;
        end
        ModeSetInt: begin
          pos_d = {coord_i, {FracBits{1'b0}}};
        end
        ModeMoveInt, ModeSetFix, ModeMoveFix: begin
          pos_d = clamped;
        end
        ModeCenter: begin
          pos_d = {ctr_pos, {FracBits{1'b0}}};
        end
        ModeTick: begin
          last_d = pos_q;
          if (ctrl_i.sel_q) begin
            hist1_d = pos_q[FixW-1:FracBits];
          end else begin
            hist0_d = pos_q[FixW-1:FracBits];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      last_q  <= '0;
      hist0_q <= '0;
      hist1_q <= '0;
    end else begin
      pos_q   <= pos_d;
      last_q  <= last_d;
      hist0_q <= hist0_d;
      hist1_q <= hist1_d;
    end
  end

  // Result fields, taken from the state as it stands after the update.
  always_comb begin
    hist_sel     = ctrl_i.sel_d ? hist1_d : hist0_d;
    round_sum    = {1'b0, pos_d} + HalfOne;
    res_o.pos    = pos_d[FixW-1:FracBits];
    res_o.scroll = round_sum[FixW:FracBits];
    res_o.delta  = {1'b0, pos_d[FixW-1:FracBits]} - {1'b0, hist_sel};
    res_o.moved  = (pos_d != last_d) || (pos_d[FixW-1:FracBits] != hist_sel);
  end

endmodule

// ===== rtl/viewport_scroll_camera_unit.sv =====
// ----------------------------------------------------------------------------
// viewport_scroll_camera_unit: two-axis scroll camera
// Input register, per-axis update logic and a result register, with the
// configuration register file on an APB-style port.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the input channel (in_valid_i / in_stall_o) with the
//   mode, coordinates, integer steps and 16.16 values. Each accepted
//   transaction produces exactly one result transaction on the output
//   channel (out_valid_o / out_stall_i) carrying the position, rounded
//   scroll pixel, delta to the selected history entry and the moved flag.
//   out_valid_o rises once a command has passed through the input register and
//   then the result register. Throughput is one transaction per cycle while
//   the receiver does not stall: the camera state is updated as a command
//   leaves the input register, so the next command already sees it.
//   When the receiver stalls, the result register holds its value and the
//   input register keeps one more command before in_stall_o rises.
//   Reset clears all camera state to zero, empties both registers and loads
//   the configuration defaults (320 x 256 world and view, single buffer).
//   Configuration must be written through psel/penable/pwrite only while no
//   command is in flight; the block does not enforce this. pready is always high.
// ----------------------------------------------------------------------------
module viewport_scroll_camera_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vsc_pkg::AddrW-1:0]  paddr,
  input  logic [vsc_pkg::DataW-1:0]  pwdata,
  output logic [vsc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  // Command channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 mode_i,
  input  logic [vsc_pkg::PosW-1:0]   coord_x_i,
  input  logic [vsc_pkg::PosW-1:0]   coord_y_i,
  input  logic signed [15:0]         step_x_i,
  input  logic signed [15:0]         step_y_i,
  input  logic signed [31:0]         fixed_x_i,
  input  logic signed [31:0]         fixed_y_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [vsc_pkg::PosW-1:0]   pos_x_o,
  output logic [vsc_pkg::PosW-1:0]   pos_y_o,
  output logic [vsc_pkg::DimW-1:0]   scroll_x_o,
  output logic [vsc_pkg::DimW-1:0]   scroll_y_o,
  output logic signed [15:0]         delta_x_o,
  output logic signed [15:0]         delta_y_o,
  output logic                       moved_o
);
  import vsc_pkg::*;

  vsc_cfg_t      cfg;
  vsc_ctrl_t     ctrl;
  vsc_axis_res_t res_x, res_y;

  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_accept, advance;
  logic sel_q, sel_d;

  logic [2:0]         mode_q;
  logic [PosW-1:0]    coord_x_q, coord_y_q;
  logic signed [15:0] step_x_q, step_y_q;
  logic signed [31:0] fixed_x_q, fixed_y_q;

  logic [PosW-1:0]    pos_x_q, pos_y_q;
  logic [DimW-1:0]    scroll_x_q, scroll_y_q;
  logic [DimW-1:0]    delta_x_q, delta_y_q;
  logic               moved_q;

  // Configuration registers.
  vsc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the command moves on whenever the result register is free or drains.
  assign advance     = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~advance;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign in_valid_d  = in_accept | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q    <= mode_i;
      coord_x_q <= coord_x_i;
      coord_y_q <= coord_y_i;
      step_x_q  <= step_x_i;
      step_y_q  <= step_y_i;
      fixed_x_q <= fixed_x_i;
      fixed_y_q <= fixed_y_i;
    end
  end

  // Buffer select: cleared by restart, flipped by a frame tick in double-buffer mode.
  always_comb begin
    sel_d = sel_q;
    if (advance) begin
      case (vsc_mode_e'(mode_q))
        ModeRestart: sel_d = 1'b0;
        ModeTick:    sel_d = sel_q ^ cfg.double_buffer;
        default:     sel_d = sel_q;
      endcase
    end
  end

  assign ctrl.advance = advance;
  assign ctrl.mode    = vsc_mode_e'(mode_q);
  assign ctrl.sel_q   = sel_q;
  assign ctrl.sel_d   = sel_d;

  // Per-axis datapaths.
  vsc_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .coord_i (coord_x_q),
    .step_i  (step_x_q),
    .fixed_i (fixed_x_q),
    .world_i (cfg.world_width),
    .view_i  (cfg.view_width),
    .res_o   (res_x)
  );

  vsc_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .coord_i (coord_y_q),
    .step_i  (step_y_q),
    .fixed_i (fixed_y_q),
    .world_i (cfg.world_height),
    .view_i  (cfg.view_height),
    .res_o   (res_y)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pos_x_q    <= res_x.pos;
      pos_y_q    <= res_y.pos;
      scroll_x_q <= res_x.scroll;
      scroll_y_q <= res_y.scroll;
      delta_x_q  <= res_x.delta;
      delta_y_q  <= res_y.delta;
      moved_q    <= res_x.moved | res_y.moved;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign scroll_x_o  = scroll_x_q;
  assign scroll_y_o  = scroll_y_q;
  assign delta_x_o   = delta_x_q;
  assign delta_y_o   = delta_y_q;
  assign moved_o     = moved_q;

  // A result that reports no movement has zero deltas on both axes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !moved_o) |-> (delta_x_o == '0 && delta_y_o == '0))
    else $error("unmoved result carries a nonzero delta");

  // A restart always leaves the first history entry selected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ctrl.mode == ModeRestart) |=> !sel_q)
    else $error("buffer select not cleared by restart");

  // Without double buffering a frame tick keeps the buffer select.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ctrl.mode == ModeTick && !cfg.double_buffer) |=> (sel_q == $past(sel_q)))
    else $error("buffer select flipped in single-buffer mode");

  // A command held in the input register is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("stalled command lost from the input register");

  // The rounded scroll position never exceeds one past the position range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (scroll_x_o <= 16'd32768 && scroll_y_o <= 16'd32768))
    else $error("scroll position out of range");

endmodule

// ===== bench/vsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsc_checker: scoreboard for the viewport scroll camera
// Watches the configuration port and both channels. Keeps its own copy of the
// camera state and registers, predicts one result per accepted command and
// compares every accepted result, field by field, against the oldest one.
// ----------------------------------------------------------------------------
module vsc_checker
  import vsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port, watched for register writes
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  // Command channel
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic [2:0]          mode_i,
  input  logic [PosW-1:0]     coord_x_i,
  input  logic [PosW-1:0]     coord_y_i,
  input  logic signed [15:0]  step_x_i,
  input  logic signed [15:0]  step_y_i,
  input  logic signed [31:0]  fixed_x_i,
  input  logic signed [31:0]  fixed_y_i,
  // Result channel
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [PosW-1:0]     pos_x_o,
  input  logic [PosW-1:0]     pos_y_o,
  input  logic [DimW-1:0]     scroll_x_o,
  input  logic [DimW-1:0]     scroll_y_o,
  input  logic signed [15:0]  delta_x_o,
  input  logic signed [15:0]  delta_y_o,
  input  logic                moved_o,
  // Verdict inputs for the top
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  // One result transaction as the block should present it.
  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [DimW-1:0] scroll_x;
    logic [DimW-1:0] scroll_y;
    logic [15:0]     delta_x;
    logic [15:0]     delta_y;
    logic            moved;
  } cam_view_t;

  cam_view_t expected_views [$];

  // Shadow camera state.
  logic [FixW-1:0] cam_x, cam_y, mark_x, mark_y;
  logic [15:0]     hist_x [2];
  logic [15:0]     hist_y [2];
  logic            sel;

  // Shadow configuration.
  logic [DimW-1:0] world_w, world_h, view_w, view_h;
  logic            dbl;

  // Largest integer position on one axis: world minus view, kept in 0..32767.
  function automatic longint axis_limit(logic [DimW-1:0] world, logic [DimW-1:0] view);
    longint m;
    m = longint'(world) - longint'(view);
    if (m < 0) m = 0;
    if (m > 32767) m = 32767;
    return m;
  endfunction

  // Clamp an exact 16.16 value into 0..limit pixels.
  function automatic logic [FixW-1:0] clamp_fix(longint v, longint lim);
    longint hi;
    hi = lim * 65536;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return FixW'(v);
  endfunction

  // Center on a coordinate: subtract half the view, then clamp.
  function automatic logic [FixW-1:0] center_fix(logic [PosW-1:0] c, logic [DimW-1:0] view,
                                                  longint lim);
    longint p;
    p = longint'(c) - longint'(view >> 1);
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    return FixW'(p * 65536);
  endfunction

  // Apply one command to the shadow state and queue the result it causes.
  task automatic track_camera(input logic [2:0] m,
                              input logic [PosW-1:0] cx, input logic [PosW-1:0] cy,
                              input logic signed [15:0] sx, input logic signed [15:0] sy,
                              input logic signed [31:0] fx, input logic signed [31:0] fy);
    longint          lx, ly;
    logic [PosW-1:0] px, py;
    logic [15:0]     hx, hy;
    logic [31:0]     rx, ry;
    cam_view_t       v;
    lx = axis_limit(world_w, view_w);
    ly = axis_limit(world_h, view_h);
    case (m)
      ModeRestart: begin
        cam_x = {cx, 16'h0000};
        cam_y = {cy, 16'h0000};
        mark_x = {cx, 16'h0000};
        mark_y = {cy, 16'h0000};
        hist_x[0] = {1'b0, cx};
        hist_x[1] = {1'b0, cx};
        hist_y[0] = {1'b0, cy};
        hist_y[1] = {1'b0, cy};
        sel = 1'b0;
      end
      ModeSetInt: begin
        // Integer sets are not clamped.
        cam_x = {cx, 16'h0000};
        cam_y = {cy, 16'h0000};
      end
      ModeMoveInt: begin
        cam_x = clamp_fix(longint'(cam_x) + longint'(sx) * 65536, lx);
        cam_y = clamp_fix(longint'(cam_y) + longint'(sy) * 65536, ly);
      end
      ModeCenter: begin
        cam_x = center_fix(cx, view_w, lx);
        cam_y = center_fix(cy, view_h, ly);
      end
      ModeTick: begin
        mark_x = cam_x;
        mark_y = cam_y;
        hist_x[sel] = {1'b0, cam_x[FixW-1:FracBits]};
        hist_y[sel] = {1'b0, cam_y[FixW-1:FracBits]};
        if (dbl) sel = ~sel;
      end
      ModeSetFix: begin
        cam_x = clamp_fix(longint'(fx), lx);
        cam_y = clamp_fix(longint'(fy), ly);
      end
      ModeMoveFix: begin
        cam_x = clamp_fix(longint'(cam_x) + longint'(fx), lx);
        cam_y = clamp_fix(longint'(cam_y) + longint'(fy), ly);
      end
      default: begin
        // The unused code leaves the state alone but still reports.
      end
    endcase

    px = cam_x[FixW-1:FracBits];
    py = cam_y[FixW-1:FracBits];
    hx = hist_x[sel];
    hy = hist_y[sel];
    rx = {1'b0, cam_x} + HalfOne;
    ry = {1'b0, cam_y} + HalfOne;
    v.pos_x = px;
    v.pos_y = py;
    v.scroll_x = rx[31:16];
    v.scroll_y = ry[31:16];
    v.delta_x = {1'b0, px} - hx;
    v.delta_y = {1'b0, py} - hy;
    v.moved = (cam_x != mark_x) || (cam_y != mark_y) ||
              ({1'b0, px} != hx) || ({1'b0, py} != hy);
    expected_views.push_back(v);
  endtask

  // Sample all three ports at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    cam_view_t want, got;
    if (!rst_ni) begin
      cam_x = '0;
      cam_y = '0;
      mark_x = '0;
      mark_y = '0;
      hist_x[0] = '0;
      hist_x[1] = '0;
      hist_y[0] = '0;
      hist_y[1] = '0;
      sel = 1'b0;
      world_w = WorldWidthRst;
      world_h = WorldHeightRst;
      view_w = ViewWidthRst;
      view_h = ViewHeightRst;
      dbl = 1'b0;
      expected_views.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      // Register writes complete in the access phase.
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          RegWorldWidth:  world_w = pwdata[DimW-1:0];
          RegWorldHeight: world_h = pwdata[DimW-1:0];
          RegViewWidth:   view_w = pwdata[DimW-1:0];
          RegViewHeight:  view_h = pwdata[DimW-1:0];
          RegDoubleBuf:   dbl = pwdata[0];
          default: ;
        endcase
      end

      // Accepted command transaction.
      if (in_valid_i && !in_stall_o) begin
        track_camera(mode_i, coord_x_i, coord_y_i, step_x_i, step_y_i, fixed_x_i, fixed_y_i);
      end

      // Accepted result transaction.
      if (out_valid_o && !out_stall_i) begin
        got.pos_x = pos_x_o;
        got.pos_y = pos_y_o;
        got.scroll_x = scroll_x_o;
        got.scroll_y = scroll_y_o;
        got.delta_x = delta_x_o;
        got.delta_y = delta_y_o;
        got.moved = moved_o;
        if (expected_views.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected result: pos %0d/%0d scroll %0d/%0d delta %0d/%0d moved %0b",
                     got.pos_x, got.pos_y, got.scroll_x, got.scroll_y,
                     $signed(got.delta_x), $signed(got.delta_y), got.moved);
          errors_o++;
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            if (errors_o < 10)
              $display("mismatch: expected pos %0d/%0d scroll %0d/%0d delta %0d/%0d moved %0b,",
                       want.pos_x, want.pos_y, want.scroll_x, want.scroll_y,
                       $signed(want.delta_x), $signed(want.delta_y), want.moved,
                       " got pos %0d/%0d scroll %0d/%0d delta %0d/%0d moved %0b",
                       got.pos_x, got.pos_y, got.scroll_x, got.scroll_y,
                       $signed(got.delta_x), $signed(got.delta_y), got.moved);
            errors_o++;
          end
        end
      end
      pending_o = expected_views.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench of the viewport scroll camera unit
// Drives commands and register writes, stalls the result channel at random,
// and gives the verdict from the failure and pending counts of the scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import vsc_pkg::*;

  localparam logic [2:0]  ModeUnused  = 3'd7;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned QuietLimit  = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         mode_i = '0;
  logic [PosW-1:0]    coord_x_i = '0;
  logic [PosW-1:0]    coord_y_i = '0;
  logic signed [15:0] step_x_i = '0;
  logic signed [15:0] step_y_i = '0;
  logic signed [31:0] fixed_x_i = '0;
  logic signed [31:0] fixed_y_i = '0;

  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PosW-1:0]    pos_x_o;
  logic [PosW-1:0]    pos_y_o;
  logic [DimW-1:0]    scroll_x_o;
  logic [DimW-1:0]    scroll_y_o;
  logic signed [15:0] delta_x_o;
  logic signed [15:0] delta_y_o;
  logic               moved_o;

  int unsigned fail_count;
  int unsigned pending;

  // Idling controls for the sender and the receiver.
  logic src_idle_on = 1'b1;
  logic snk_idle_on = 1'b1;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  int unsigned quiet_cycles = 0;

  viewport_scroll_camera_unit dut (.*);

  vsc_checker chk (
    .*,
    .errors_o  (fail_count),
    .pending_o (pending)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("** viewport_scroll_camera_unit: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
        out_stall_i = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        n = $urandom_range(1, 15);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  // Single register write: setup cycle, then access cycle.
  task automatic apb_write(input vsc_reg_e r, input logic [DataW-1:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Offer one command transaction and wait until it is taken.
  task automatic push_cmd(input logic [2:0] m,
                          input logic [PosW-1:0] cx, input logic [PosW-1:0] cy,
                          input logic signed [15:0] sx, input logic signed [15:0] sy,
                          input logic signed [31:0] fx, input logic signed [31:0] fy);
    int unsigned gap;
    @(negedge clk_i);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i = m;
    coord_x_i = cx;
    coord_y_i = cy;
    step_x_i = sx;
    step_y_i = sy;
    fixed_x_i = fx;
    fixed_y_i = fy;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Let every outstanding result arrive so the block is idle.
  task automatic drain_camera();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write all five registers.
  task automatic write_geometry(input logic [15:0] ww, input logic [15:0] wh,
                                input logic [15:0] vw, input logic [15:0] vh,
                                input logic db);
    apb_write(RegWorldWidth, DataW'(ww));
    apb_write(RegWorldHeight, DataW'(wh));
    apb_write(RegViewWidth, DataW'(vw));
    apb_write(RegViewHeight, DataW'(vh));
    apb_write(RegDoubleBuf, DataW'(db));
  endtask

  function automatic logic [PosW-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return PosW'($urandom_range(0, 63));
      1: return PosW'($urandom);
      2: return PosW'($urandom_range(0, 2000));
      default: return PosW'($urandom_range(32700, 32767));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_step();
    case ($urandom_range(0, 3))
      0, 1: return 16'(int'($urandom_range(0, 128)) - 64);
      2: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_fix();
    case ($urandom_range(0, 5))
      0, 1: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($urandom);
      3: return 32'((int'($urandom_range(0, 256)) - 128) << 16);
      4: return 32'($urandom_range(0, 2000 << 16));
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_8000;
          default: return 32'shFFFF_8000;
        endcase
      end
    endcase
  endfunction

  // One random command, biased toward moves and frame ticks.
  task automatic random_cmd();
    int unsigned pick;
    logic [2:0]  m;
    pick = $urandom_range(0, 99);
    if (pick < 5) m = ModeRestart;
    else if (pick < 15) m = ModeSetInt;
    else if (pick < 35) m = ModeMoveInt;
    else if (pick < 45) m = ModeCenter;
    else if (pick < 65) m = ModeTick;
    else if (pick < 75) m = ModeSetFix;
    else if (pick < 95) m = ModeMoveFix;
    else m = ModeUnused;
    push_cmd(m, pick_coord(), pick_coord(), pick_step(), pick_step(), pick_fix(), pick_fix());
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned p;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Default geometry: world equals view, so every clamp lands on zero.
    push_cmd(ModeRestart, 15'd5, 15'd7, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeSetInt, 15'd100, 15'd200, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeTick, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeMoveInt, 15'd0, 15'd0, 16'sd1, 16'sd1, 32'sd0, 32'sd0);
    push_cmd(ModeCenter, 15'd200, 15'd300, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeSetInt, 15'h7FFF, 15'h7FFF, 16'sd0, 16'sd0, 32'sd0, 32'sd0);

    // Widest range with double buffering: limit capped at 32767.
    drain_camera();
    write_geometry(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 1'b1);
    push_cmd(ModeRestart, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeRestart, 15'h7FFF, 15'h7FFF, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeSetInt, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeMoveInt, 15'd0, 15'd0, 16'sh7FFF, 16'sh7FFF, 32'sd0, 32'sd0);
    push_cmd(ModeMoveInt, 15'd0, 15'd0, 16'sh8000, 16'sh8000, 32'sd0, 32'sd0);
    push_cmd(ModeSetFix, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_cmd(ModeSetFix, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sh8000_0000, 32'sh8000_0000);
    // Half-pixel fractions exercise the rounding.
    push_cmd(ModeSetFix, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sh0001_8000, 32'sh0000_7FFF);
    push_cmd(ModeMoveFix, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sh0000_7FFF, 32'sh0000_8000);
    push_cmd(ModeTick, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeMoveFix, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'shFFFF_0000, 32'shFFFF_8000);
    push_cmd(ModeTick, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeCenter, 15'h7FFF, 15'h7FFF, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeCenter, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    // The unused code must leave the state untouched.
    push_cmd(ModeUnused, 15'h7FFF, 15'h5555, 16'shFFFF, 16'sh7FFF, 32'shFFFF_FFFF,
             32'sh1234_5678);
    push_cmd(ModeMoveFix, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sh0001_0000, 32'sh0002_0000);
    push_cmd(ModeTick, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeSetInt, 15'h7FFF, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    push_cmd(ModeTick, 15'd0, 15'd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);

    // Random phases, each with its own geometry.
    for (p = 0; p < NumPhases; p++) begin
      drain_camera();
      case (p)
        0: write_geometry(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 1'b1);
        1: write_geometry(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        2: write_geometry(16'd1000, 16'd800, 16'd320, 16'd240, 1'b1);
        3: write_geometry(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                          16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)),
                          1'($urandom));
        4: write_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        5: write_geometry(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
                          16'($urandom_range(1, 65535)), 1'($urandom));
        6: write_geometry(16'd40000, 16'd33000, 16'd3, 16'd7, 1'b0);
        default: write_geometry(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                                16'($urandom_range(1, 500)), 16'($urandom_range(1, 500)),
                                1'b1);
      endcase
      // The last phase runs at full rate on both sides.
      src_idle_on = (p != NumPhases - 1);
      snk_idle_on = (p != NumPhases - 1);
      // Long receiver hold-off while commands keep coming.
      if (p == 3) hold_req = 1'b1;
      repeat (PhaseItems) random_cmd();
    end

    // Wait for the tail and for any stray results.
    drain_camera();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** viewport_scroll_camera_unit: PASSED **");
    end else begin
      $display("** viewport_scroll_camera_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vsc_pkg.sv
rtl/vsc_cfg_regs.sv
rtl/vsc_axis.sv
rtl/viewport_scroll_camera_unit.sv
bench/vsc_checker.sv
bench/tb.sv
